/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold: cons must be true in the same cycle as ante
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// advance: cons must be true in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/spac_pkg.sv */
// ----------------------------------------------------------------------------
// spac_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spac_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;
  localparam int TURN_W       = 32;
  localparam int RES_W        = TURN_W - 2;
  localparam int CORD_W       = 34;
  localparam int ZW           = 33;
  localparam int TRIG_W       = 32;
  localparam int VALUE_W      = 16;
  localparam int COORD_W      = 17;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int PROD_SHIFT   = 46;
  localparam int SINGLE_SHIFT = 16;
  localparam int RND_W        = ACC_W - PROD_SHIFT;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_TORUS  = 1'b0,
    MODE_SPHERE = 1'b1
  } surf_mode_t;

  typedef struct packed {
    surf_mode_t              mode;
    logic [ANGLE_BITS-1:0]   azimuth;
    logic [ANGLE_BITS-1:0]   polar;
  } point_item_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 33'sh20000000;
      5'd1:    v = 33'sh12E4051E;
      5'd2:    v = 33'sh09FB385B;
      5'd3:    v = 33'sh051111D4;
      5'd4:    v = 33'sh028B0D43;
      5'd5:    v = 33'sh0145D7E1;
      5'd6:    v = 33'sh00A2F61E;
      5'd7:    v = 33'sh00517C55;
      5'd8:    v = 33'sh0028BE53;
      5'd9:    v = 33'sh00145F2F;
      5'd10:   v = 33'sh000A2F98;
      5'd11:   v = 33'sh000517CC;
      5'd12:   v = 33'sh00028BE6;
      5'd13:   v = 33'sh000145F3;
      5'd14:   v = 33'sh0000A2FA;
      5'd15:   v = 33'sh0000517D;
      5'd16:   v = 33'sh000028BE;
      5'd17:   v = 33'sh0000145F;
      5'd18:   v = 33'sh00000A30;
      5'd19:   v = 33'sh00000518;
      5'd20:   v = 33'sh0000028C;
      5'd21:   v = 33'sh00000146;
      5'd22:   v = 33'sh000000A3;
      5'd23:   v = 33'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/spac_queue.sv */
// ----------------------------------------------------------------------------
// spac_queue
// Short FIFO of point items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spac_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  spac_pkg::point_item_t item_in,
  output logic                  full,
  input  logic                  pop,
  output spac_pkg::point_item_t item_out,
  output logic                  empty
);
  import spac_pkg::*;

  point_item_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= item_in;
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/spac_front.sv */
// ----------------------------------------------------------------------------
// spac_front
// Accepts commands, keeps the angle state and mode, queues wrapped angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spac_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_command,
  input  logic signed [spac_pkg::VALUE_W-1:0]   in_azimuth_value,
  input  logic signed [spac_pkg::VALUE_W-1:0]   in_polar_value,
  output logic                                  q_push,
  output spac_pkg::point_item_t                 q_item,
  input  logic                                  q_full
);
  import spac_pkg::*;

  surf_mode_t              mode_r;
  logic [ANGLE_BITS-1:0]   az_r;
  logic [ANGLE_BITS-1:0]   po_r;
  logic [ANGLE_BITS-1:0]   az_nxt;
  logic [ANGLE_BITS-1:0]   po_nxt;
  logic signed [ANGLE_BITS-1:0] az_ext;
  logic signed [ANGLE_BITS-1:0] po_ext;
  logic [ANGLE_BITS-1:0]   az_sum;
  logic [ANGLE_BITS-1:0]   po_sum;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    az_ext = ANGLE_BITS'(in_azimuth_value);
    po_ext = ANGLE_BITS'(in_polar_value);
    az_sum = az_r + az_ext;
    po_sum = po_r + po_ext;
    if (in_command == CMD_MOVE) begin
      az_nxt = az_sum;
      if (mode_r == MODE_SPHERE) begin
        po_nxt = {1'b0, po_sum[ANGLE_BITS-2:0]};
      end else begin
        po_nxt = po_sum;
      end
    end else begin
      az_nxt = az_ext;
      po_nxt = po_ext;
    end
    q_item.mode    = mode_r;
    q_item.azimuth = az_nxt;
    q_item.polar   = po_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TORUS;
      az_r   <= '0;
      po_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= surf_mode_t'(cfg_wr_data);
      end
      if (q_push) begin
        az_r <= az_nxt;
        po_r <= po_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/spac_cordic.sv */
// ----------------------------------------------------------------------------
// spac_cordic
// Iterative rotation-mode CORDIC, one step per cycle, quadrant fold-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spac_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [spac_pkg::ANGLE_BITS-1:0]       angle,
  output logic                                  done,
  output logic signed [spac_pkg::TRIG_W-1:0]    cos_q,
  output logic signed [spac_pkg::TRIG_W-1:0]    sin_q
);
  import spac_pkg::*;

  logic signed [CORD_W-1:0] x_r;
  logic signed [CORD_W-1:0] y_r;
  logic signed [ZW-1:0]     z_r;
  logic [STEP_W-1:0]        step_r;
  logic [1:0]               quad_r;
  logic                     busy_r;
  logic                     done_r;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic signed [CORD_W-1:0] neg_x;
  logic signed [CORD_W-1:0] neg_y;
  logic signed [ZW-1:0]     at;
  logic [RES_W-1:0]         residue;

  assign done    = done_r;
  assign residue = {angle[ANGLE_BITS-3:0], {(TURN_W - ANGLE_BITS){1'b0}}};

  always_comb begin
    dx    = y_r >>> step_r;
    dy    = x_r >>> step_r;
    at    = atan_turn(ATAN_IDX_W'(step_r));
    neg_x = -x_r;
    neg_y = -y_r;
    case (quad_r)
      2'd0: begin
        cos_q = TRIG_W'(x_r);
        sin_q = TRIG_W'(y_r);
      end
      2'd1: begin
        cos_q = TRIG_W'(neg_y);
        sin_q = TRIG_W'(x_r);
      end
      2'd2: begin
        cos_q = TRIG_W'(neg_x);
        sin_q = TRIG_W'(neg_y);
      end
      default: begin
        cos_q = TRIG_W'(y_r);
        sin_q = TRIG_W'(neg_x);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= ZW'(residue);
        quad_r <= angle[ANGLE_BITS-1 -: 2];
      end else if (busy_r) begin
        if (!z_r[ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + STEP_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/spac_back.sv */
// ----------------------------------------------------------------------------
// spac_back
// Runs both CORDICs, forms the surface products, rounds and holds a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spac_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  spac_pkg::point_item_t                 q_item,
  output logic                                  q_pop,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [spac_pkg::COORD_W-1:0]   out_x_coord,
  output logic signed [spac_pkg::COORD_W-1:0]   out_y_coord,
  output logic signed [spac_pkg::COORD_W-1:0]   out_z_coord
);
  import spac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_FIN_Y,
    ST_OUT
  } state_t;

  localparam logic signed [RND_W-1:0]   LIM_LO   = RND_W'(-(2 ** (COORD_W - 1)));
  localparam logic signed [RND_W-1:0]   LIM_HI   = RND_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [COORD_W-1:0] COORD_LO = COORD_W'(-(2 ** (COORD_W - 1)));
  localparam logic signed [COORD_W-1:0] COORD_HI = COORD_W'((2 ** (COORD_W - 1)) - 1);

  state_t                    state_r;
  surf_mode_t                mode_r;
  logic                      out_valid_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [COORD_W-1:0] x_res_r;
  logic signed [COORD_W-1:0] y_res_r;
  logic signed [COORD_W-1:0] z_res_r;
  logic signed [COORD_W-1:0] x_out_r;
  logic signed [COORD_W-1:0] y_out_r;
  logic signed [COORD_W-1:0] z_out_r;
  logic                      az_done;
  logic                      po_done;
  logic signed [TRIG_W-1:0]  az_cos;
  logic signed [TRIG_W-1:0]  az_sin;
  logic signed [TRIG_W-1:0]  po_cos;
  logic signed [TRIG_W-1:0]  po_sin;
  logic signed [TRIG_W-1:0]  mul_a;
  logic signed [TRIG_W-1:0]  z_src;
  logic                      start;
  logic                      is_torus;

  function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [RND_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v < LIM_LO) begin
      r = COORD_LO;
    end else if (v > LIM_HI) begin
      r = COORD_HI;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] round_prod(
    input logic signed [PROD_W-1:0] p,
    input logic signed [TRIG_W-1:0] c,
    input logic                     torus
  );
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] rad;
    logic signed [ACC_W-1:0] sum;
    ext = ACC_W'(c);
    rad = torus ? ((ext <<< 31) + (ext <<< 30)) : '0;
    sum = ACC_W'(p) + rad + (ACC_W'(1) <<< (PROD_SHIFT - 1));
    return clamp_coord(signed'(sum[ACC_W-1:PROD_SHIFT]));
  endfunction

  function automatic logic signed [COORD_W-1:0] round_single(input logic signed [TRIG_W-1:0] c);
    logic signed [TRIG_W:0] sum;
    sum = (TRIG_W + 1)'(c) + ((TRIG_W + 1)'(1) <<< (SINGLE_SHIFT - 1));
    return clamp_coord(RND_W'(signed'(sum[TRIG_W:SINGLE_SHIFT])));
  endfunction

  assign start       = (state_r == ST_IDLE) && !q_empty;
  assign q_pop       = start;
  assign out_empty   = !out_valid_r;
  assign out_x_coord = x_out_r;
  assign out_y_coord = y_out_r;
  assign out_z_coord = z_out_r;
  assign is_torus    = (mode_r == MODE_TORUS);
  assign mul_a       = is_torus ? po_cos : po_sin;
  assign z_src       = is_torus ? po_sin : po_cos;

  spac_cordic u_cordic_az (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .angle (q_item.azimuth),
    .done  (az_done),
    .cos_q (az_cos),
    .sin_q (az_sin)
  );

  spac_cordic u_cordic_po (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .angle (q_item.polar),
    .done  (po_done),
    .cos_q (po_cos),
    .sin_q (po_sin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_TORUS;
    end else begin
      if (out_pop && out_valid_r && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            mode_r  <= q_item.mode;
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (az_done && po_done) begin
            state_r <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          prod_r  <= mul_a * az_cos;
          z_res_r <= round_single(z_src);
          state_r <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          prod_r  <= mul_a * az_sin;
          x_res_r <= round_prod(prod_r, az_cos, is_torus);
          state_r <= ST_FIN_Y;
        end
        ST_FIN_Y: begin
          y_res_r <= round_prod(prod_r, az_sin, is_torus);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_pop) begin
            x_out_r     <= x_res_r;
            y_out_r     <= y_res_r;
            z_out_r     <= z_res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/surface_point_angle_to_cartesian_top.sv */
// ----------------------------------------------------------------------------
// surface_point_angle_to_cartesian_top
// Keeps one point's azimuth and polar binary angles and converts each update
// to Cartesian x, y, z in signed Q3.14 on a torus or a unit sphere.
//
// Input: in_push/in_full. A set command loads both angles, a move command
// adds signed deltas with wrap. Every transfer yields exactly one result.
// Output: out_empty/out_pop; the oldest result sits on out_*_coord while
// out_empty is low. cfg_wr_en/cfg_wr_data write the surface mode.
// An item goes from input transfer to result through the 16
// one-step-per-cycle iterations of the two CORDIC units that run side by
// side, then the shared multiplier in ST_MUL_X and ST_MUL_Y, and rounding.
// The back end takes a new item only after it has passed on the last one.
// A two-entry queue takes items while the back end works; a held result
// lets the back end finish the next item, then it waits until out_pop.
// Reset: angles zero, torus mode, queue empty, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module surface_point_angle_to_cartesian_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_command,
  input  logic signed [spac_pkg::VALUE_W-1:0]   in_azimuth_value,
  input  logic signed [spac_pkg::VALUE_W-1:0]   in_polar_value,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [spac_pkg::COORD_W-1:0]   out_x_coord,
  output logic signed [spac_pkg::COORD_W-1:0]   out_y_coord,
  output logic signed [spac_pkg::COORD_W-1:0]   out_z_coord
);
  import spac_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  point_item_t q_in;
  point_item_t q_out;

  spac_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_azimuth_value (in_azimuth_value),
    .in_polar_value   (in_polar_value),
    .q_push           (q_push),
    .q_item           (q_in),
    .q_full           (q_full)
  );

  spac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  spac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_x_coord (out_x_coord),
    .out_y_coord (out_y_coord),
    .out_z_coord (out_z_coord)
  );

  `ASSERT_SAME(a_no_push_full, q_push, !q_full, "push into full queue")
  `ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
  `ASSERT_NEXT(a_pop_frees, q_full && q_pop && !q_push, !q_full, "pop did not free queue")

endmodule

`default_nettype wire
